FILE: hdl/assert_macros.svh
// assertion macros shared by the matcher modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at each rising clock edge, held off while reset is low
`define STM_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// condition that must never be seen at a rising clock edge
`define STM_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`endif

FILE: hdl/stm_pkg.sv
// types, constants and hash helpers of the segment timestamp matcher
package stm_pkg;

    localparam int KEY_W        = 128;
    localparam int STAMP_W      = 63;
    localparam int HASH_W       = 32;
    localparam int HASH_STEPS   = KEY_W / HASH_W;
    localparam int HASH_CNT_W   = $clog2(HASH_STEPS);
    localparam int DIV_CNT_W    = $clog2(HASH_W);
    localparam int ENTRIES_W    = 17;
    localparam int HASH_FOLD    = 5;
    localparam logic [HASH_W-1:0]    HASH_MULT     = 32'd37;
    localparam logic [ENTRIES_W-1:0] ENTRIES_RESET = 17'd57251;

    // configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam logic REG_TABLE_ENTRIES = 1'b0;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OUTCOME_STORED   = 2'd0,
        OUTCOME_COLLIDED = 2'd1,
        OUTCOME_MATCHED  = 2'd2
    } outcome_t;

    typedef struct packed {
        logic [31:0]        source_address;
        logic [31:0]        dest_address;
        logic [15:0]        source_port;
        logic [15:0]        dest_port;
        logic [31:0]        sequence_number;
        logic [STAMP_W-1:0] stamp_us;
    } stm_in_t;

    typedef struct packed {
        outcome_t           outcome;
        logic [STAMP_W-1:0] latency_us;
    } stm_out_t;

    // key and stamp of one observation, also the layout of a table slot
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [STAMP_W-1:0] stamp;
    } stm_job_t;

    typedef struct packed {
        logic busy;
        logic done;
    } stm_div_stat_t;

    // key in wire order, first hashed byte in the top bits
    function automatic logic [KEY_W-1:0] key_of(input stm_in_t d);
        return {d.source_address, d.dest_address, d.source_port, d.dest_port,
                d.sequence_number};
    endfunction

    // four bytes of h = h*37 + byte, most significant byte first
    function automatic logic [HASH_W-1:0] hash_word(input logic [HASH_W-1:0] h_in,
                                                    input logic [HASH_W-1:0] w);
        logic [HASH_W-1:0] h;
        h = h_in;
        for (int i = HASH_W / 8 - 1; i >= 0; i--) begin
            h = h * HASH_MULT + HASH_W'(w[i*8 +: 8]);
        end
        return h;
    endfunction

endpackage

FILE: hdl/segment_timestamp_matcher.sv
// top level of the segment timestamp matcher
// the front end takes a new observation only once the last one is in the queue;
// its pace is set by the bit-serial remainder unit
// the table engine reads a slot, then writes it back, and runs behind a two-beat queue
// reset: synchronous, active low; table_entries returns to 57251
// after reset a clearing pass empties every slot, s_ready stays low meanwhile
module segment_timestamp_matcher #(
    parameter int TABLE_DEPTH = 65536,
    localparam int IDX_W = $clog2(TABLE_DEPTH)
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    // observation channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  stm_pkg::stm_in_t                    s_data,

    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output stm_pkg::stm_out_t                   m_data,

    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [stm_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [stm_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [stm_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    localparam int QW = $bits(stm_pkg::stm_job_t) + IDX_W;

    // slot count register, only one in the map
    logic [stm_pkg::ENTRIES_W-1:0]  entries_reg, entries_next;
    logic                           reg_sel;

    // front end to queue
    logic                           fr_s_ready;
    logic                           fr_q_valid, fr_q_ready;
    stm_pkg::stm_job_t              fr_q_job;
    logic [IDX_W-1:0]               fr_q_idx;

    // queue to table engine
    logic                           bk_q_valid, bk_q_ready;
    logic [QW-1:0]                  bk_q_data;
    logic                           init_done;

    // register decode on the word address
    assign reg_sel = (paddr[stm_pkg::APB_ADDR_W-1] == stm_pkg::REG_TABLE_ENTRIES);
    assign pready  = 1'b1;

    always_comb begin
        entries_next = entries_reg;
        if (psel && penable && pwrite && pready && reg_sel) begin
            entries_next = pwdata[stm_pkg::ENTRIES_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entries_reg <= stm_pkg::ENTRIES_RESET;
        end else begin
            entries_reg <= entries_next;
        end
    end

    // read-back of the slot count, unmapped addresses read zero
    always_comb begin
        prdata = '0;
        if (reg_sel) prdata = stm_pkg::APB_DATA_W'(entries_reg);
    end

    // no observations are taken until the clearing pass is over
    assign s_ready = fr_s_ready && init_done;

    stm_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid && init_done),
        .s_ready     (fr_s_ready),
        .s_data      (s_data),
        .cfg_entries (entries_reg),
        .q_valid     (fr_q_valid),
        .q_ready     (fr_q_ready),
        .q_job       (fr_q_job),
        .q_idx       (fr_q_idx)
    );

    // key, stamp and slot index travel together through the queue
    stm_fifo #(
        .W (QW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_q_valid),
        .in_ready  (fr_q_ready),
        .in_data   ({fr_q_job, fr_q_idx}),
        .out_valid (bk_q_valid),
        .out_ready (bk_q_ready),
        .out_data  (bk_q_data)
    );

    stm_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (bk_q_valid),
        .q_ready   (bk_q_ready),
        .q_job     (bk_q_data[QW-1:IDX_W]),
        .q_idx     (bk_q_data[IDX_W-1:0]),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .init_done (init_done)
    );

endmodule

FILE: hdl/stm_div.sv
// bit-serial remainder unit for the slot index
`include "assert_macros.svh"

module stm_div #(
    parameter int TABLE_DEPTH = 65536,
    localparam int IDX_W  = $clog2(TABLE_DEPTH),
    localparam int SLOT_W = IDX_W + 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [stm_pkg::HASH_W-1:0]  dividend,
    input  logic [SLOT_W-1:0]           divisor,
    output stm_pkg::stm_div_stat_t      stat,
    output logic [IDX_W-1:0]            remainder
);

    logic                               busy_reg, busy_next;
    logic                               done_reg, done_next;
    logic [stm_pkg::DIV_CNT_W-1:0]      cnt_reg, cnt_next;
    logic [stm_pkg::HASH_W-1:0]         num_reg, num_next;
    logic [IDX_W-1:0]                   rem_reg, rem_next;
    logic [SLOT_W-1:0]                  d_reg, d_next;
    logic [SLOT_W-1:0]                  trial;

    assign trial = {rem_reg, num_reg[stm_pkg::HASH_W-1]};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = stm_pkg::DIV_CNT_W'(stm_pkg::HASH_W - 1);
            num_next  = dividend;
            rem_next  = '0;
            d_next    = divisor;
        end else if (busy_reg) begin
            // restoring step: remainder stays below the divisor
            if (trial >= d_reg) begin
                rem_next = IDX_W'(trial - d_reg);
            end else begin
                rem_next = IDX_W'(trial);
            end
            num_next = {num_reg[stm_pkg::HASH_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        num_reg <= num_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign remainder = rem_reg;

    `STM_ASSERT(a_div_start_idle, aclk, aresetn, start |-> !busy_reg, "divide started while busy")
    `STM_ASSERT(a_div_rem_range, aclk, aresetn, done_reg |-> ({1'b0, rem_reg} < d_reg), "remainder not below divisor")

endmodule

FILE: hdl/stm_front.sv
// front end: takes an observation, hashes its key and reduces it to a slot index
module stm_front #(
    parameter int TABLE_DEPTH = 65536,
    localparam int IDX_W  = $clog2(TABLE_DEPTH),
    localparam int SLOT_W = IDX_W + 1
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  stm_pkg::stm_in_t                s_data,
    input  logic [stm_pkg::ENTRIES_W-1:0]   cfg_entries,
    output logic                            q_valid,
    input  logic                            q_ready,
    output stm_pkg::stm_job_t               q_job,
    output logic [IDX_W-1:0]                q_idx
);

    typedef enum logic [4:0] {
        FR_IDLE  = 5'b00001,
        FR_HASH  = 5'b00010,
        FR_START = 5'b00100,
        FR_DIV   = 5'b01000,
        FR_HOLD  = 5'b10000
    } fr_state_t;

    localparam logic [SLOT_W-1:0] DEPTH_SLOTS = SLOT_W'(TABLE_DEPTH);

    fr_state_t                          state_reg, state_next;
    stm_pkg::stm_job_t                  job_reg;
    logic [stm_pkg::KEY_W-1:0]          key_sh_reg;
    logic [stm_pkg::HASH_W-1:0]         h_reg;
    logic [stm_pkg::HASH_CNT_W-1:0]     cnt_reg;
    logic [IDX_W-1:0]                   idx_reg;
    logic [SLOT_W-1:0]                  slots;
    logic [stm_pkg::HASH_W-1:0]         folded;
    logic                               div_start;
    stm_pkg::stm_div_stat_t             div_stat;
    logic [IDX_W-1:0]                   div_rem;

    // zero slots means one, more than the table holds means all of it
    always_comb begin
        if (cfg_entries == '0) begin
            slots = SLOT_W'(1);
        end else if (32'(cfg_entries) > 32'(TABLE_DEPTH)) begin
            slots = DEPTH_SLOTS;
        end else begin
            slots = SLOT_W'(cfg_entries);
        end
    end

    assign folded    = h_reg + (h_reg >> stm_pkg::HASH_FOLD);
    assign div_start = (state_reg == FR_START);

    stm_div #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (folded),
        .divisor   (slots),
        .stat      (div_stat),
        .remainder (div_rem)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FR_IDLE: begin
                if (s_valid) state_next = FR_HASH;
            end
            FR_HASH: begin
                if (cnt_reg == stm_pkg::HASH_CNT_W'(stm_pkg::HASH_STEPS - 1)) begin
                    state_next = FR_START;
                end
            end
            FR_START: state_next = FR_DIV;
            FR_DIV: begin
                if (div_stat.done) state_next = FR_HOLD;
            end
            FR_HOLD: begin
                if (q_ready) state_next = FR_IDLE;
            end
            default: state_next = FR_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FR_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            FR_IDLE: begin
                if (s_valid) begin
                    job_reg.key   <= stm_pkg::key_of(s_data);
                    job_reg.stamp <= s_data.stamp_us;
                    key_sh_reg    <= stm_pkg::key_of(s_data);
                    h_reg         <= '0;
                    cnt_reg       <= '0;
                end
            end
            FR_HASH: begin
                // one 32-bit word of the key per cycle
                h_reg      <= stm_pkg::hash_word(h_reg,
                                  key_sh_reg[stm_pkg::KEY_W-1 -: stm_pkg::HASH_W]);
                key_sh_reg <= {key_sh_reg[stm_pkg::KEY_W-stm_pkg::HASH_W-1:0],
                               stm_pkg::HASH_W'(0)};
                cnt_reg    <= cnt_reg + 1'b1;
            end
            FR_DIV: begin
                if (div_stat.done) idx_reg <= div_rem;
            end
            default: begin
            end
        endcase
    end

    assign s_ready = (state_reg == FR_IDLE);
    assign q_valid = (state_reg == FR_HOLD);
    assign q_job   = job_reg;
    assign q_idx   = idx_reg;

endmodule

FILE: hdl/stm_fifo.sv
// two-entry queue between front end and table engine
module stm_fifo #(
    parameter int W = 8
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [W-1:0]    in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [W-1:0]    out_data
);

    logic [W-1:0]                       mem_reg [stm_pkg::QUEUE_DEPTH];
    logic [stm_pkg::QUEUE_PTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [stm_pkg::QUEUE_CNT_W-1:0]    cnt_reg, cnt_next;
    logic                               push, pop;

    assign in_ready  = (cnt_reg != stm_pkg::QUEUE_CNT_W'(stm_pkg::QUEUE_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) cnt_next = cnt_reg + 1'b1;
        if (pop && !push) cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop) rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= in_data;
    end

endmodule

FILE: hdl/stm_back.sv
// table engine: slot read-modify-write and result register
`include "assert_macros.svh"

module stm_back #(
    parameter int TABLE_DEPTH = 65536,
    localparam int IDX_W = $clog2(TABLE_DEPTH)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_ready,
    input  stm_pkg::stm_job_t   q_job,
    input  logic [IDX_W-1:0]    q_idx,
    output logic                m_valid,
    input  logic                m_ready,
    output stm_pkg::stm_out_t   m_data,
    output logic                init_done
);

    typedef enum logic [2:0] {
        BK_CLEAR = 3'b001,
        BK_IDLE  = 3'b010,
        BK_LOOK  = 3'b100
    } bk_state_t;

    stm_pkg::stm_job_t                  mem [TABLE_DEPTH];

    bk_state_t                          state_reg, state_next;
    logic [IDX_W-1:0]                   clr_cnt_reg;
    stm_pkg::stm_job_t                  job_reg;
    logic [IDX_W-1:0]                   idx_reg;
    stm_pkg::stm_job_t                  rdata_reg;
    logic                               m_valid_reg, m_valid_next;
    stm_pkg::stm_out_t                  m_data_reg, m_data_next;

    logic                               pop, out_free, finish;
    logic                               slot_empty, slot_hit;
    logic [stm_pkg::STAMP_W-1:0]        diff;
    logic                               we;
    logic [IDX_W-1:0]                   waddr;
    stm_pkg::stm_job_t                  wdata;

    assign pop      = (state_reg == BK_IDLE) && q_valid;
    assign out_free = !m_valid_reg || m_ready;
    assign finish   = (state_reg == BK_LOOK) && out_free;

    assign slot_empty = (rdata_reg.key == '0);
    assign slot_hit   = (rdata_reg.key == job_reg.key);

    always_comb begin
        if (job_reg.stamp >= rdata_reg.stamp) begin
            diff = job_reg.stamp - rdata_reg.stamp;
        end else begin
            diff = rdata_reg.stamp - job_reg.stamp;
        end
    end

    // outcome and slot update, and zero slots during the clearing pass
    always_comb begin
        wdata       = job_reg;
        m_data_next = m_data_reg;
        if (finish) begin
            m_data_next.latency_us = '0;
            if (slot_empty) begin
                m_data_next.outcome = stm_pkg::OUTCOME_STORED;
            end else if (!slot_hit) begin
                m_data_next.outcome = stm_pkg::OUTCOME_COLLIDED;
            end else begin
                m_data_next.outcome    = stm_pkg::OUTCOME_MATCHED;
                m_data_next.latency_us = diff;
                wdata.key   = '0;
                wdata.stamp = rdata_reg.stamp;
            end
        end
        if (state_reg == BK_CLEAR) begin
            wdata = '0;
        end
    end

    assign we    = (state_reg == BK_CLEAR) || finish;
    assign waddr = (state_reg == BK_CLEAR) ? clr_cnt_reg : idx_reg;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) m_valid_next = 1'b0;
        if (finish) m_valid_next = 1'b1;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_CLEAR: begin
                if (clr_cnt_reg == IDX_W'(TABLE_DEPTH - 1)) state_next = BK_IDLE;
            end
            BK_IDLE: begin
                if (q_valid) state_next = BK_LOOK;
            end
            BK_LOOK: begin
                if (out_free) state_next = BK_IDLE;
            end
            default: state_next = BK_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (state_reg == BK_CLEAR) clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (pop) begin
            job_reg <= q_job;
            idx_reg <= q_idx;
        end
    end

    // slot table: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        if (pop) rdata_reg <= mem[q_idx];
    end

    assign q_ready   = (state_reg == BK_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign init_done = (state_reg != BK_CLEAR);

    `STM_ASSERT(a_bk_pop_look, aclk, aresetn, pop |=> (state_reg == BK_LOOK), "slot read not followed by update")
    `STM_NEVER(a_bk_clear_quiet, aclk, aresetn, (state_reg == BK_CLEAR) && m_valid_reg, "result during clearing pass")
    `STM_ASSERT(a_bk_lat_zero, aclk, aresetn, (m_valid_reg && (m_data_reg.outcome != stm_pkg::OUTCOME_MATCHED)) |-> (m_data_reg.latency_us == '0), "latency without match")

endmodule
